// ----- hdl/dsaf_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, register codes and the pipeline sideband type of the spring force block
package dsaf_pkg;

    localparam int LANES     = 3;
    localparam int MUL_LANES = 5;
    localparam int SQ_STEPS  = 33;
    localparam int DIV_STEPS = 17;

    localparam logic [61:0] SAT_MAG       = '1;
    localparam logic [31:0] FORCE_POS_MAX = 32'h7fff_ffff;
    localparam logic [31:0] FORCE_NEG_MAX = 32'h8000_0000;

    localparam logic [30:0] STIFF_RST = 31'd65536;
    localparam logic [30:0] REST_RST  = 31'd655360;
    localparam logic [30:0] DAMP_RST  = 31'd65536;

    typedef enum logic [2:0] {
        REG_ANCHOR_X = 3'd0,
        REG_ANCHOR_Y = 3'd1,
        REG_ANCHOR_Z = 3'd2,
        REG_STIFF    = 3'd3,
        REG_REST     = 3'd4,
        REG_DAMP     = 3'd5
    } t_reg;

    // everything an item carries down the pipe; each stage fills in its own fields
    typedef struct packed {
        logic             zero;
        logic [2:0]       dneg;
        logic [2:0][32:0] dmag;
        logic [2:0][31:0] vel;
        logic [30:0]      im;
        logic [30:0]      dt;
        logic [45:0]      w2;
        logic [45:0]      cm;
        logic [32:0]      len;
        logic [2:0][16:0] q;
        logic             dist_neg;
        logic [33:0]      dist_mag;
        logic [34:0]      vp;
        logic             pw_neg;
        logic [61:0]      pw_mag;
        logic [61:0]      pc_mag;
        logic             cneg;
        logic [61:0]      cmag;
        logic [2:0][61:0] m;
        logic [2:0]       mneg;
    } t_side;

endpackage

// ----- hdl/dsaf_mul.sv -----
`timescale 1ns / 1ps
// multi-lane 64x64 unsigned multiplier, two stages, sideband carried alongside
module dsaf_mul import dsaf_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  t_side                        i_side,
    input  logic [MUL_LANES-1:0][63:0]   i_a,
    input  logic [MUL_LANES-1:0][63:0]   i_b,
    output logic                         o_vld,
    output t_side                        o_side,
    output logic [MUL_LANES-1:0][127:0]  o_p
);

    logic [MUL_LANES-1:0][3:0][63:0] r_pp;
    logic [MUL_LANES-1:0][127:0]     r_p;
    logic                            r_v1;
    logic                            r_v2;
    t_side                           r_s1;
    t_side                           r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    // 32x32 partial products first, then one wide sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= i_side;
            r_s2 <= r_s1;
            for (int l = 0; l < MUL_LANES; l++) begin
                r_pp[l][0] <= 64'(i_a[l][31:0]) * 64'(i_b[l][31:0]);
                r_pp[l][1] <= 64'(i_a[l][31:0]) * 64'(i_b[l][63:32]);
                r_pp[l][2] <= 64'(i_a[l][63:32]) * 64'(i_b[l][31:0]);
                r_pp[l][3] <= 64'(i_a[l][63:32]) * 64'(i_b[l][63:32]);
                r_p[l] <= {64'd0, r_pp[l][0]} + {32'd0, r_pp[l][1], 32'd0}
                        + {32'd0, r_pp[l][2], 32'd0} + {r_pp[l][3], 64'd0};
            end
        end
    end

    assign o_vld  = r_v2;
    assign o_side = r_s2;
    assign o_p    = r_p;

endmodule

// ----- hdl/dsaf_sqrt.sv -----
`timescale 1ns / 1ps
// pipelined integer square root of a 66-bit value, one result bit per stage
module dsaf_sqrt import dsaf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [65:0] i_val,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [32:0] o_root,
    output t_side       o_side
);

    logic [33:0] r_rem  [SQ_STEPS];
    logic [32:0] r_root [SQ_STEPS];
    logic [65:0] r_rad  [SQ_STEPS];
    t_side       r_side [SQ_STEPS];
    logic [SQ_STEPS-1:0] r_vld;
    logic [33:0] n_rem  [SQ_STEPS];
    logic [32:0] n_root [SQ_STEPS];
    logic [65:0] n_rad  [SQ_STEPS];

    always_comb begin
        logic [33:0] rem_in;
        logic [32:0] root_in;
        logic [65:0] rad_in;
        logic [35:0] cur;
        logic [35:0] trial;
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = i_val;
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
                rad_in  = r_rad[k-1];
            end
            cur   = {rem_in, rad_in[65:64]};
            trial = {1'b0, root_in, 2'b01};
            if (cur >= trial) begin
                n_rem[k]  = 34'(cur - trial);
                n_root[k] = {root_in[31:0], 1'b1};
            end else begin
                n_rem[k]  = cur[33:0];
                n_root[k] = {root_in[31:0], 1'b0};
            end
            n_rad[k] = {rad_in[63:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQ_STEPS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[SQ_STEPS-1];
    assign o_root = r_root[SQ_STEPS-1];
    assign o_side = r_side[SQ_STEPS-1];

endmodule

// ----- hdl/dsaf_div.sv -----
`timescale 1ns / 1ps
// three-lane pipelined restoring divider for the unit direction, one quotient bit per stage
module dsaf_div import dsaf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_side            i_side,
    output logic             o_vld,
    output t_side            o_side,
    output logic [2:0][16:0] o_q
);

    logic [2:0][32:0] r_rem  [DIV_STEPS];
    logic [2:0][16:0] r_q    [DIV_STEPS];
    t_side            r_side [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_vld;
    logic [2:0][32:0] n_rem  [DIV_STEPS];
    logic [2:0][16:0] n_q    [DIV_STEPS];

    // numerator is dmag << 16; since dmag <= len the quotient fits 17 bits
    always_comb begin
        logic [32:0] rem_in;
        logic [16:0] q_in;
        logic [32:0] den;
        logic        dig_in;
        logic [33:0] cur;
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int l = 0; l < LANES; l++) begin
                if (k == 0) begin
                    rem_in = {1'b0, i_side.dmag[l][32:1]};
                    q_in   = '0;
                    den    = i_side.len;
                    dig_in = i_side.dmag[l][0];
                end else begin
                    rem_in = r_rem[k-1][l];
                    q_in   = r_q[k-1][l];
                    den    = r_side[k-1].len;
                    dig_in = 1'b0;
                end
                cur = {rem_in, dig_in};
                if (cur >= {1'b0, den}) begin
                    n_rem[k][l] = 33'(cur - {1'b0, den});
                    n_q[k][l]   = {q_in[15:0], 1'b1};
                end else begin
                    n_rem[k][l] = cur[32:0];
                    n_q[k][l]   = {q_in[15:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= n_q[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];
    assign o_q    = r_q[DIV_STEPS-1];

endmodule

// ----- hdl/damped_spring_anchor_force_top.sv -----
`timescale 1ns / 1ps
// top level of the damped spring anchor force pipeline with its register port
// Usage: program anchor, stiffness, rest length and damping over the register
// port (byte address 4*index), then stream particles in on s_axis. Each input
// transfer carries position, velocity, inverse mass and time step; each output
// transfer on m_axis carries the saturated force increment and an applied flag
// (cleared when the particle sits exactly on the anchor).
// The path from an input transfer to its result on m_axis runs through the
// 33-stage square root, the 17-stage divider and five two-stage multiplier
// groups. One transfer per cycle is sustained while the receiver takes results.
// Reset clears all valid bits and loads the register defaults (anchor at the
// origin, stiffness 1.0, rest length 10.0, damping 1.0).
// When the receiver stalls with a result waiting, the whole pipe holds, bubbles
// included, and s_axis_tready follows m_axis_tready until the result is taken.
module damped_spring_anchor_force_top import dsaf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, inverse_mass, time_step, 2 pad bits
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // force_x, force_y, force_z
    output logic [95:0]  m_axis_tdata,
    // applied
    output logic         m_axis_tuser
);

    logic [31:0] r_anchor [LANES];
    logic [30:0] r_stiff;
    logic [30:0] r_rest;
    logic [30:0] r_damp;
    t_reg        w_reg;

    logic        w_en;

    logic        r_va;
    t_side       r_sa;
    t_side       n_sa;

    logic                        w_m1_vld;
    t_side                       w_m1_side;
    logic [MUL_LANES-1:0][63:0]  w_m1_a;
    logic [MUL_LANES-1:0][63:0]  w_m1_b;
    logic [MUL_LANES-1:0][127:0] w_m1_p;

    logic        r_vs;
    t_side       r_ss;
    t_side       n_ss;
    logic [65:0] r_sum;

    logic        w_sq_vld;
    logic [32:0] w_sq_root;
    t_side       w_sq_side;
    t_side       w_dv_in;

    logic             w_dv_vld;
    t_side            w_dv_side;
    logic [2:0][16:0] w_dv_q;

    logic        r_ve;
    t_side       r_se;
    t_side       n_se;

    logic                        w_m2_vld;
    t_side                       w_m2_side;
    logic [MUL_LANES-1:0][63:0]  w_m2_a;
    logic [MUL_LANES-1:0][63:0]  w_m2_b;
    logic [MUL_LANES-1:0][127:0] w_m2_p;

    logic        r_vc;
    t_side       r_sc;
    t_side       n_sc;

    logic                        w_m3_vld;
    t_side                       w_m3_side;
    logic [MUL_LANES-1:0][63:0]  w_m3_a;
    logic [MUL_LANES-1:0][63:0]  w_m3_b;
    logic [MUL_LANES-1:0][127:0] w_m3_p;

    logic        r_vd;
    t_side       r_sd;
    t_side       n_sd;

    logic        r_vk;
    t_side       r_sk;
    t_side       n_sk;

    logic                        w_m4_vld;
    t_side                       w_m4_side;
    logic [MUL_LANES-1:0][63:0]  w_m4_a;
    logic [MUL_LANES-1:0][63:0]  w_m4_b;
    logic [MUL_LANES-1:0][127:0] w_m4_p;

    logic        r_vm;
    t_side       r_sm;
    t_side       n_sm;

    logic                        w_m5_vld;
    t_side                       w_m5_side;
    logic [MUL_LANES-1:0][63:0]  w_m5_a;
    logic [MUL_LANES-1:0][63:0]  w_m5_b;
    logic [MUL_LANES-1:0][127:0] w_m5_p;

    logic             r_vo;
    logic [2:0][31:0] r_force;
    logic [2:0][31:0] n_force;
    logic             r_applied;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) begin
                r_anchor[l] <= '0;
            end
            r_stiff <= STIFF_RST;
            r_rest  <= REST_RST;
            r_damp  <= DAMP_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg)
                REG_ANCHOR_X: r_anchor[0] <= pwdata;
                REG_ANCHOR_Y: r_anchor[1] <= pwdata;
                REG_ANCHOR_Z: r_anchor[2] <= pwdata;
                REG_STIFF:    r_stiff     <= pwdata[30:0];
                REG_REST:     r_rest      <= pwdata[30:0];
                REG_DAMP:     r_damp      <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_ANCHOR_X: prdata = r_anchor[0];
            REG_ANCHOR_Y: prdata = r_anchor[1];
            REG_ANCHOR_Z: prdata = r_anchor[2];
            REG_STIFF:    prdata = {1'b0, r_stiff};
            REG_REST:     prdata = {1'b0, r_rest};
            REG_DAMP:     prdata = {1'b0, r_damp};
            default:      prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    assign w_en          = !r_vo || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage a: offset to the anchor, split into sign and magnitude
    always_comb begin
        logic [32:0] dv;
        n_sa = '0;
        for (int l = 0; l < LANES; l++) begin
            dv = {r_anchor[l][31], r_anchor[l]}
               - {s_axis_tdata[32*l+31], s_axis_tdata[32*l +: 32]};
            n_sa.dneg[l]  = dv[32];
            n_sa.dmag[l]  = dv[32] ? 33'(-dv) : dv;
            n_sa.vel[l]   = s_axis_tdata[96+32*l +: 32];
        end
        n_sa.zero = (n_sa.dmag[0] == '0) && (n_sa.dmag[1] == '0) && (n_sa.dmag[2] == '0);
        n_sa.im   = s_axis_tdata[222:192];
        n_sa.dt   = s_axis_tdata[253:223];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_en) begin
            r_va <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sa <= n_sa;
        end
    end

    // squares of the offset, w^2 and damping product
    always_comb begin
        w_m1_a = '0;
        w_m1_b = '0;
        for (int l = 0; l < LANES; l++) begin
            w_m1_a[l] = 64'(r_sa.dmag[l]);
            w_m1_b[l] = 64'(r_sa.dmag[l]);
        end
        w_m1_a[3] = 64'(r_sa.im);
        w_m1_b[3] = 64'(r_stiff);
        w_m1_a[4] = 64'(r_damp);
        w_m1_b[4] = 64'(r_sa.im);
    end

    dsaf_mul u_mul_sq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_va),
        .i_side (r_sa),
        .i_a    (w_m1_a),
        .i_b    (w_m1_b),
        .o_vld  (w_m1_vld),
        .o_side (w_m1_side),
        .o_p    (w_m1_p)
    );

    // stage s: squared length, scaled w^2 and damping product
    always_comb begin
        n_ss    = w_m1_side;
        n_ss.w2 = w_m1_p[3][61:16];
        n_ss.cm = w_m1_p[4][61:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
        end else if (w_en) begin
            r_vs <= w_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= w_m1_p[0][65:0] + w_m1_p[1][65:0] + w_m1_p[2][65:0];
            r_ss  <= n_ss;
        end
    end

    dsaf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_vs),
        .i_val  (r_sum),
        .i_side (r_ss),
        .o_vld  (w_sq_vld),
        .o_root (w_sq_root),
        .o_side (w_sq_side)
    );

    always_comb begin
        w_dv_in     = w_sq_side;
        w_dv_in.len = w_sq_root;
    end

    dsaf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_sq_vld),
        .i_side (w_dv_in),
        .o_vld  (w_dv_vld),
        .o_side (w_dv_side),
        .o_q    (w_dv_q)
    );

    // stage e: unit direction in, distance from rest length
    always_comb begin
        logic [33:0] ds;
        n_se   = w_dv_side;
        n_se.q = w_dv_q;
        ds     = {3'b000, r_rest} - {1'b0, w_dv_side.len};
        n_se.dist_neg = ds[33];
        n_se.dist_mag = ds[33] ? 34'(-ds) : ds;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (w_en) begin
            r_ve <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_se <= n_se;
        end
    end

    // velocity along the axis and the spring term
    always_comb begin
        w_m2_a = '0;
        w_m2_b = '0;
        for (int l = 0; l < LANES; l++) begin
            w_m2_a[l] = r_se.vel[l][31] ? 64'(32'(-r_se.vel[l])) : 64'(r_se.vel[l]);
            w_m2_b[l] = 64'(r_se.q[l]);
        end
        w_m2_a[3] = 64'(r_se.w2);
        w_m2_b[3] = 64'(r_se.dist_mag);
    end

    dsaf_mul u_mul_proj (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_ve),
        .i_side (r_se),
        .i_a    (w_m2_a),
        .i_b    (w_m2_b),
        .o_vld  (w_m2_vld),
        .o_side (w_m2_side),
        .o_p    (w_m2_p)
    );

    // stage c: projected velocity sum, saturated spring term
    // a raw product that overflows 64 bits saturates the whole term
    always_comb begin
        logic [34:0] term;
        n_sc    = w_m2_side;
        n_sc.vp = '0;
        for (int l = 0; l < LANES; l++) begin
            term = {3'b000, w_m2_p[l][47:16]};
            if (w_m2_side.vel[l][31] ^ w_m2_side.dneg[l]) begin
                term = 35'(-term);
            end
            n_sc.vp = n_sc.vp + term;
        end
        n_sc.pw_neg = w_m2_side.dist_neg;
        n_sc.pw_mag = (|w_m2_p[3][127:64]) ? SAT_MAG : 62'(w_m2_p[3][63:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (w_en) begin
            r_vc <= w_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sc <= n_sc;
        end
    end

    // damping term
    always_comb begin
        w_m3_a    = '0;
        w_m3_b    = '0;
        w_m3_a[0] = 64'(r_sc.cm);
        w_m3_b[0] = r_sc.vp[34] ? 64'(35'(-r_sc.vp)) : 64'(r_sc.vp);
    end

    dsaf_mul u_mul_damp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_vc),
        .i_side (r_sc),
        .i_a    (w_m3_a),
        .i_b    (w_m3_b),
        .o_vld  (w_m3_vld),
        .o_side (w_m3_side),
        .o_p    (w_m3_p)
    );

    // stage d: saturated damping magnitude
    always_comb begin
        n_sd        = w_m3_side;
        n_sd.pc_mag = (|w_m3_p[0][127:64]) ? SAT_MAG : 62'(w_m3_p[0][63:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (w_en) begin
            r_vd <= w_m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd <= n_sd;
        end
    end

    // stage k: coeff = -(spring + damping) in sign-magnitude, clamped
    always_comb begin
        logic [62:0] sum;
        logic [62:0] dab;
        logic [62:0] dba;
        logic        pcn;
        n_sk = r_sd;
        pcn  = r_sd.vp[34];
        sum  = {1'b0, r_sd.pw_mag} + {1'b0, r_sd.pc_mag};
        dab  = {1'b0, r_sd.pw_mag} - {1'b0, r_sd.pc_mag};
        dba  = {1'b0, r_sd.pc_mag} - {1'b0, r_sd.pw_mag};
        if (r_sd.pw_neg == pcn) begin
            n_sk.cneg = !r_sd.pw_neg;
            n_sk.cmag = sum[62] ? SAT_MAG : sum[61:0];
        end else if (!dab[62]) begin
            n_sk.cneg = !r_sd.pw_neg;
            n_sk.cmag = dab[61:0];
        end else begin
            n_sk.cneg = !pcn;
            n_sk.cmag = dba[61:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vk <= 1'b0;
        end else if (w_en) begin
            r_vk <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sk <= n_sk;
        end
    end

    // direction times coefficient
    always_comb begin
        w_m4_a = '0;
        w_m4_b = '0;
        for (int l = 0; l < LANES; l++) begin
            w_m4_a[l] = 64'(r_sk.cmag);
            w_m4_b[l] = 64'(r_sk.q[l]);
        end
    end

    dsaf_mul u_mul_dir (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_vk),
        .i_side (r_sk),
        .i_a    (w_m4_a),
        .i_b    (w_m4_b),
        .o_vld  (w_m4_vld),
        .o_side (w_m4_side),
        .o_p    (w_m4_p)
    );

    // stage m: per-axis coefficient, saturated once the raw product passes 64 bits
    always_comb begin
        n_sm = w_m4_side;
        for (int l = 0; l < LANES; l++) begin
            n_sm.m[l]    = (|w_m4_p[l][127:64]) ? SAT_MAG : 62'(w_m4_p[l][63:16]);
            n_sm.mneg[l] = w_m4_side.dneg[l] ^ w_m4_side.cneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (w_en) begin
            r_vm <= w_m4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sm <= n_sm;
        end
    end

    // scale by the time step
    always_comb begin
        w_m5_a = '0;
        w_m5_b = '0;
        for (int l = 0; l < LANES; l++) begin
            w_m5_a[l] = 64'(r_sm.m[l]);
            w_m5_b[l] = 64'(r_sm.dt);
        end
    end

    dsaf_mul u_mul_dt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r_vm),
        .i_side (r_sm),
        .i_a    (w_m5_a),
        .i_b    (w_m5_b),
        .o_vld  (w_m5_vld),
        .o_side (w_m5_side),
        .o_p    (w_m5_p)
    );

    // output stage: clamp to 32-bit signed, zero on the anchor
    always_comb begin
        logic [31:0] mag;
        for (int l = 0; l < LANES; l++) begin
            mag = {1'b0, w_m5_p[l][46:16]};
            if (w_m5_side.zero) begin
                n_force[l] = '0;
            end else if (|w_m5_p[l][127:47]) begin
                n_force[l] = w_m5_side.mneg[l] ? FORCE_NEG_MAX : FORCE_POS_MAX;
            end else begin
                n_force[l] = w_m5_side.mneg[l] ? 32'(-mag) : mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_vo <= w_m5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_force   <= n_force;
            r_applied <= !w_m5_side.zero;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = r_force;
    assign m_axis_tuser  = r_applied;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for the damped spring anchor force block: directed rows, then random streams
module tb_top;
    import dsaf_pkg::*;

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic signed [31:0] vx, vy, vz;
        logic [30:0]        im;
        logic [30:0]        dt;
    } t_particle;

    typedef struct packed {
        logic signed [31:0] fx, fy, fz;
        logic               applied;
    } t_force;

    typedef struct packed {
        t_particle p;
        logic      typed;
        t_force    f;
    } t_row;

    localparam longint SAT = 64'h3fff_ffff_ffff_ffff;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int NPHASES = 7;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, inverse_mass, time_step, 2 pad bits
    logic [255:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // force_x, force_y, force_z
    logic [95:0]  m_axis_tdata;
    // applied
    logic         m_axis_tuser;

    damped_spring_anchor_force_top i_dut (.*);

    // register copies used by the predictor
    logic signed [31:0] anc_x = '0, anc_y = '0, anc_z = '0;
    logic [30:0]        k_reg = STIFF_RST, rest_reg = REST_RST, damp_reg = DAMP_RST;

    t_force expected_forces[$];
    t_row   rows[$];
    int     errors = 0;
    int     sent = 0, received = 0;
    int     snd_idle = 0, rcv_idle = 0;
    bit     hold_req = 0;
    int     hold_left = 0;
    int     quiet = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] magn(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    // signed q16.16 product, magnitude truncated and saturated
    function automatic longint qprod(longint a, longint b);
        logic [127:0] pr;
        logic [63:0]  p;
        pr = {64'b0, magn(a)} * {64'b0, magn(b)};
        if (pr[127:64] != 0) p = SAT;
        else begin
            p = pr[63:0] >> 16;
            if (p > SAT) p = SAT;
        end
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_force spring_force(t_particle p);
        t_force       r;
        longint       d[3], v[3], u[3];
        logic [67:0]  sumsq, root, rem, trial;
        logic [63:0]  len, q;
        longint       vp, w2, cm, stretch, coeff, f;
        d[0] = longint'(anc_x) - longint'(p.px);
        d[1] = longint'(anc_y) - longint'(p.py);
        d[2] = longint'(anc_z) - longint'(p.pz);
        v[0] = p.vx; v[1] = p.vy; v[2] = p.vz;
        r = '0;
        if (d[0] == 0 && d[1] == 0 && d[2] == 0) return r;
        sumsq = '0;
        for (int i = 0; i < 3; i++) sumsq += {4'b0, magn(d[i]) * magn(d[i])};
        root = '0;
        rem = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | 68'(sumsq[2*i +: 2]);
            trial = (root << 2) | 68'd1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 68'd1;
            end else begin
                root = root << 1;
            end
        end
        len = root[63:0];
        vp = 0;
        for (int i = 0; i < 3; i++) begin
            q = (magn(d[i]) << 16) / len;
            u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
            vp += qprod(v[i], u[i]);
        end
        w2 = longint'(({33'b0, p.im} * {33'b0, k_reg}) >> 16);
        cm = longint'(({33'b0, damp_reg} * {33'b0, p.im}) >> 16);
        stretch = longint'({33'b0, rest_reg}) - longint'(len);
        coeff = clampl(-qprod(w2, stretch) - qprod(cm, vp), -SAT, SAT);
        f = clampl(qprod(qprod(u[0], coeff), longint'(p.dt)), -64'sh8000_0000, 64'sh7fff_ffff);
        r.fx = f[31:0];
        f = clampl(qprod(qprod(u[1], coeff), longint'(p.dt)), -64'sh8000_0000, 64'sh7fff_ffff);
        r.fy = f[31:0];
        f = clampl(qprod(qprod(u[2], coeff), longint'(p.dt)), -64'sh8000_0000, 64'sh7fff_ffff);
        r.fz = f[31:0];
        r.applied = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch at result %0d: %s got %h want %h", received, what, got, want);
    endtask

    task automatic reg_write(t_reg idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ANCHOR_X: anc_x = val;
            REG_ANCHOR_Y: anc_y = val;
            REG_ANCHOR_Z: anc_z = val;
            REG_STIFF:    k_reg = val[30:0];
            REG_REST:     rest_reg = val[30:0];
            REG_DAMP:     damp_reg = val[30:0];
            default: ;
        endcase
    endtask

    // one input transfer; valid stays high between back-to-back items
    task automatic send_particle(t_particle p, bit typed, t_force want);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b0, p.dt, p.im, p.vz, p.vy, p.vx, p.pz, p.py, p.px};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_forces.push_back(typed ? want : spring_force(p));
        sent++;
    endtask

    function automatic t_particle random_particle();
        t_particle p;
        int kind;
        kind = $urandom_range(9);
        p.px = $urandom; p.py = $urandom; p.pz = $urandom;
        p.vx = $urandom; p.vy = $urandom; p.vz = $urandom;
        p.im = 31'($urandom); p.dt = 31'($urandom);
        if (kind <= 5) begin
            // realistic particle near the anchor
            p.px = anc_x + $signed($urandom_range(2621440)) - 32'sd1310720;
            p.py = anc_y + $signed($urandom_range(2621440)) - 32'sd1310720;
            p.pz = anc_z + $signed($urandom_range(2621440)) - 32'sd1310720;
            p.vx = $signed($urandom_range(1310720)) - 32'sd655360;
            p.vy = $signed($urandom_range(1310720)) - 32'sd655360;
            p.vz = $signed($urandom_range(1310720)) - 32'sd655360;
            p.im = 31'($urandom_range(262144));
            p.dt = 31'($urandom_range(6554));
        end else if (kind == 7) begin
            p.px = anc_x; p.py = anc_y; p.pz = anc_z;
        end else if (kind == 8) begin
            p.im = $urandom_range(1) ? 31'h7fff_ffff : 31'd0;
            p.dt = $urandom_range(1) ? 31'h7fff_ffff : 31'd0;
        end else if (kind == 9) begin
            p.px = anc_x + $signed($urandom_range(255)) - 32'sd128;
            p.py = anc_y;
            p.pz = anc_z - $signed($urandom_range(3));
        end
        return p;
    endfunction

    function automatic t_row mkrow(logic [31:0] px, py, pz, vx, vy, vz,
                                   logic [30:0] im, dt, logic typed,
                                   logic [31:0] fx, fy, fz, logic ap);
        t_row r;
        r.p = {px, py, pz, vx, vy, vz, im, dt};
        r.typed = typed;
        r.f = {fx, fy, fz, ap};
        return r;
    endfunction

    // result side: checks every transfer, idles at random and holds off on request
    initial begin
        t_force got, want;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                       m_axis_tuser};
                received++;
                if (expected_forces.size() == 0) begin
                    errors++;
                    $display("result %0d arrived with nothing expected", received);
                end else begin
                    want = expected_forces.pop_front();
                    if (got.fx !== want.fx) report_mismatch("force_x", got.fx, want.fx);
                    if (got.fy !== want.fy) report_mismatch("force_y", got.fy, want.fy);
                    if (got.fz !== want.fz) report_mismatch("force_z", got.fz, want.fz);
                    if (got.applied !== want.applied)
                        report_mismatch("applied", 32'(got.applied), 32'(want.applied));
                end
            end
            if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", quiet);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default registers: anchor at origin, k 1.0, rest 10.0, c 1.0
        rows.push_back(mkrow(0, 0, 0, 32'h7fff_ffff, 0, 32'h8000_0000, 31'h10000, 31'h10000,
                             1'b1, 0, 0, 0, 1'b0));
        rows.push_back(mkrow(32'h30000, 0, 0, 32'h10000, 0, 0, 31'd0, 31'h10000,
                             1'b1, 0, 0, 0, 1'b1));
        rows.push_back(mkrow(0, 32'h40000, 0, 0, 32'h10000, 0, 31'h10000, 31'd0,
                             1'b1, 0, 0, 0, 1'b1));
        // particle at rest length with no velocity: no force
        rows.push_back(mkrow(32'ha0000, 0, 0, 0, 0, 0, 31'h10000, 31'h10000,
                             1'b1, 0, 0, 0, 1'b1));
        rows.push_back(mkrow(32'h30000, 32'h40000, 0, 32'h8000, 32'hffff8000, 0,
                             31'h10000, 31'h1999, 1'b0, 0, 0, 0, 1'b0));
        rows.push_back(mkrow(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             31'h7fff_ffff, 31'h7fff_ffff, 1'b0, 0, 0, 0, 1'b0));
        rows.push_back(mkrow(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             31'h7fff_ffff, 31'h7fff_ffff, 1'b0, 0, 0, 0, 1'b0));
        rows.push_back(mkrow(32'h8000_0000, 32'h7fff_ffff, 1, 32'hffff_ffff, 1, 0,
                             31'h1, 31'h1, 1'b0, 0, 0, 0, 1'b0));
        rows.push_back(mkrow(1, 0, 0, 0, 0, 0, 31'h7fff_ffff, 31'h7fff_ffff,
                             1'b0, 0, 0, 0, 1'b0));
        rows.push_back(mkrow(0, 0, 32'hffff_ffff, 32'h7fff_ffff, 0, 0, 31'h7fff_ffff,
                             31'h10000, 1'b0, 0, 0, 0, 1'b0));
        rows.push_back(mkrow(32'h0a0000, 32'h0a0000, 32'h0a0000, 32'h2_0000, 0,
                             32'hfffe_0000, 31'h2_0000, 31'h8000, 1'b0, 0, 0, 0, 1'b0));
        snd_idle = 28;
        rcv_idle = 88;
        foreach (rows[i]) send_particle(rows[i].p, rows[i].typed, rows[i].f);

        for (int ph = 1; ph < NPHASES; ph++) begin
            s_axis_tvalid <= 1'b0;
            wait (expected_forces.size() == 0);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            case (ph)
                1: begin
                    reg_write(REG_ANCHOR_X, 32'h7fff_ffff);
                    reg_write(REG_ANCHOR_Y, 32'h7fff_ffff);
                    reg_write(REG_ANCHOR_Z, 32'h7fff_ffff);
                    reg_write(REG_STIFF, 32'h7fff_ffff);
                    reg_write(REG_REST, 32'h7fff_ffff);
                    reg_write(REG_DAMP, 32'h7fff_ffff);
                end
                2: begin
                    reg_write(REG_ANCHOR_X, 32'h8000_0000);
                    reg_write(REG_ANCHOR_Y, 32'h8000_0000);
                    reg_write(REG_ANCHOR_Z, 32'h8000_0000);
                    reg_write(REG_STIFF, 32'h0);
                    reg_write(REG_REST, 32'h0);
                    reg_write(REG_DAMP, 32'h0);
                end
                default: begin
                    reg_write(REG_ANCHOR_X, $urandom);
                    reg_write(REG_ANCHOR_Y, $urandom);
                    reg_write(REG_ANCHOR_Z, $urandom);
                    reg_write(REG_STIFF, $urandom_range(655360));
                    reg_write(REG_REST, $urandom_range(1310720));
                    reg_write(REG_DAMP, $urandom_range(655360));
                end
            endcase
            if (ph < 3) begin
                snd_idle = 28; rcv_idle = 88;
            end else if (ph < 5) begin
                snd_idle = 88; rcv_idle = 28;
            end else begin
                snd_idle = 0; rcv_idle = 0;
                // long hold-off so the pipe fills and stalls its input
                if (ph == 5) hold_req = 1;
            end
            n = (ph == 1 || ph == 2) ? 80 : 170;
            repeat (n) send_particle(random_particle(), 0, '0);
        end
        s_axis_tvalid <= 1'b0;

        wait (expected_forces.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d particles over %0d register settings, %0d forces checked",
                 sent, NPHASES, received);
        $display("included on-anchor, zero mass, zero step, saturation and a long output stall");
        if (errors == 0 && expected_forces.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ----- damped_spring_anchor_force_top.f -----
hdl/dsaf_pkg.sv
hdl/dsaf_mul.sv
hdl/dsaf_sqrt.sv
hdl/dsaf_div.sv
hdl/damped_spring_anchor_force_top.sv
bench/tb_top.sv
